>>> hw/rtl/mfq_pkg.sv
package mfq_pkg;

    // Sequencer states; the datapath acts on the state it is handed.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WAKE,
        ST_SLICE0,
        ST_AGE_RD,
        ST_AGE_Q,
        ST_AGE_P,
        ST_RUN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PUSH,
        ST_HEAD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        state_t op;
        logic   accept;
    } ctrl_t;

    typedef struct packed {
        logic wake_ok;
        logic slice_ok;
        logic age_end;
        logic lv_zero;
        logic q_self;
        logic remove_need;
        logic shift_end;
        logic push_en;
        logic out_free;
    } status_t;

    localparam logic [1:0] CMD_ADMIT = 2'd0;
    localparam logic [1:0] CMD_WAKE  = 2'd1;
    localparam logic [1:0] CMD_SLICE = 2'd2;

    localparam logic [2:0] CFG_QUANTUM_TOP    = 3'd0;
    localparam logic [2:0] CFG_QUANTUM_SECOND = 3'd1;
    localparam logic [2:0] CFG_QUANTUM_THIRD  = 3'd2;
    localparam logic [2:0] CFG_AGING_SECOND   = 3'd3;
    localparam logic [2:0] CFG_AGING_THIRD    = 3'd4;
    localparam logic [2:0] CFG_AGING_BOTTOM   = 3'd5;

    localparam logic [5:0] QUANTUM_TOP_RST    = 6'd8;
    localparam logic [5:0] QUANTUM_SECOND_RST = 6'd16;
    localparam logic [5:0] QUANTUM_THIRD_RST  = 6'd32;
    localparam logic [8:0] AGING_SECOND_RST   = 9'd160;
    localparam logic [8:0] AGING_THIRD_RST    = 9'd320;
    localparam logic [8:0] AGING_BOTTOM_RST   = 9'd500;

    localparam logic [8:0] WAIT_MAX    = 9'd511;
    localparam logic [5:0] RUN_MAX     = 6'd63;
    localparam logic [1:0] TOP_LEVEL   = 2'd3;
    localparam int         ID_SPACE    = 64;
    localparam int         LEVEL_COUNT = 4;

endpackage

>>> hw/rtl/mfq_ctrl.sv
module mfq_ctrl
    import mfq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ctrl.op     = state_reg;
        ctrl.accept = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.wake_ok)
                    state_next = ST_WAKE;
                else if (status.slice_ok)
                    state_next = ST_SLICE0;
                else
                    state_next = ST_HEAD;
            end
            ST_WAKE:     state_next = ST_HEAD;
            ST_SLICE0:   state_next = ST_AGE_RD;
            ST_AGE_RD:
            begin
                if (!status.age_end)
                    state_next = ST_AGE_Q;
                else if (status.lv_zero)
                    state_next = ST_RUN;
            end
            ST_AGE_Q:    state_next = status.q_self ? ST_AGE_RD : ST_AGE_P;
            ST_AGE_P:    state_next = ST_AGE_RD;
            ST_RUN:      state_next = status.remove_need ? ST_SHIFT_RD : ST_HEAD;
            ST_SHIFT_RD:
            begin
                if (!status.shift_end)
                    state_next = ST_SHIFT_WR;
                else
                    state_next = status.push_en ? ST_PUSH : ST_HEAD;
            end
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_PUSH:     state_next = ST_HEAD;
            ST_HEAD:     state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/mfq_datapath.sv
module mfq_datapath
    import mfq_pkg::*;
#(
    parameter int PROCESS_COUNT = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic [1:0] command,
    input  logic [5:0] process,
    input  logic       still_runnable,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       next_valid,
    output logic [5:0] next_process,
    output logic [1:0] next_level,
    output logic       rejected,
    output logic       demoted,
    output logic [6:0] promoted_count,
    input  ctrl_t      ctrl,
    output status_t    status
);

    localparam int SLOTS = (PROCESS_COUNT < ID_SPACE) ? PROCESS_COUNT : ID_SPACE;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(SLOTS + 1);
    localparam int QW    = 2 + SW;
    localparam int QD    = LEVEL_COUNT * (1 << SW);

    // Process record: level, run count, wait count.
    localparam logic [16:0] REC_RST = {TOP_LEVEL, 6'd0, 9'd0};

    logic [5:0]  queue_mem [QD];
    logic [16:0] proc_mem  [SLOTS];

    logic [5:0] q_top_reg, q_top_next, q_sec_reg, q_sec_next, q_thr_reg, q_thr_next;
    logic [8:0] a_sec_reg, a_sec_next, a_thr_reg, a_thr_next, a_bot_reg, a_bot_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [5:0]       p_reg, p_next;
    logic             runnable_reg, runnable_next;
    logic [SLOTS-1:0] queued_reg, queued_next;
    logic [SLOTS-1:0] touched_reg, touched_next;
    logic [LW-1:0]    len_reg [LEVEL_COUNT];
    logic [LW-1:0]    len_next [LEVEL_COUNT];
    logic [1:0]       lv_reg, lv_next, cur_reg, cur_next, push_lv_reg, push_lv_next;
    logic [LW-1:0]    i_reg, i_next, k_reg, k_next, pos_reg, pos_next;
    logic [5:0]       prun_reg, prun_next;
    logic             push_en_reg, push_en_next;
    logic [6:0]       promo_reg, promo_next;
    logic             rej_reg, rej_next, dem_reg, dem_next;

    logic       out_valid_reg, out_valid_next, nv_reg, nv_next, orej_reg, orej_next;
    logic       odem_reg, odem_next;
    logic [5:0] np_reg, np_next;
    logic [1:0] nl_reg, nl_next;
    logic [6:0] opc_reg, opc_next;

    logic [5:0]    qm_rdata_reg;
    logic [16:0]   pm_rdata_reg;
    logic          pm_touch_reg;
    logic          qm_we, pm_we;
    logic [QW-1:0] qm_wa, qm_ra;
    logic [5:0]    qm_wd;
    logic [SW-1:0] pm_wa, pm_ra;
    logic [16:0]   pm_wd, pd;

    logic [SW-1:0] p_idx, q_idx;
    logic          in_range, out_free, any;
    logic [1:0]    top, lvl_up, cur_dn;
    logic [LW-1:0] i1;
    logic [8:0]    w, limit;
    logic [5:0]    r, quantum;
    logic          demote;

    assign p_idx    = p_reg[SW-1:0];
    assign q_idx    = qm_rdata_reg[SW-1:0];
    assign in_range = {26'd0, p_reg} < PROCESS_COUNT;
    assign pd       = pm_touch_reg ? pm_rdata_reg : REC_RST;
    assign out_free = !out_valid_reg || out_ready;
    assign i1       = i_reg + LW'(1);
    assign lvl_up   = lv_reg + 2'd1;
    assign cur_dn   = cur_reg - 2'd1;
    assign w        = (pd[8:0] == WAIT_MAX) ? WAIT_MAX : pd[8:0] + 9'd1;
    assign r        = (prun_reg == RUN_MAX) ? RUN_MAX : prun_reg + 6'd1;
    assign demote   = (cur_reg != 2'd0) && (r >= quantum);

    always_comb
    begin
        unique case (lv_reg)
            2'd2:    limit = a_sec_reg;
            2'd1:    limit = a_thr_reg;
            default: limit = a_bot_reg;
        endcase
        unique case (cur_reg)
            2'd3:    quantum = q_top_reg;
            2'd2:    quantum = q_sec_reg;
            default: quantum = q_thr_reg;
        endcase
        any = 1'b1;
        priority if (len_reg[3] != '0) top = 2'd3;
        else if (len_reg[2] != '0)     top = 2'd2;
        else if (len_reg[1] != '0)     top = 2'd1;
        else
        begin
            top = 2'd0;
            any = (len_reg[0] != '0);
        end
    end

    always_comb
    begin
        status.wake_ok     = (cmd_reg == CMD_WAKE) && in_range && !queued_reg[p_idx];
        status.slice_ok    = (cmd_reg == CMD_SLICE) && in_range && queued_reg[p_idx];
        status.age_end     = (i_reg == len_reg[lv_reg]);
        status.lv_zero     = (lv_reg == 2'd0);
        status.q_self      = (qm_rdata_reg == p_reg);
        status.remove_need = !((cur_reg == 2'd0) && runnable_reg);
        status.shift_end   = (i1 >= len_reg[cur_reg]);
        status.push_en     = push_en_reg;
        status.out_free    = out_free;
    end

    always_comb
    begin
        q_top_next = q_top_reg; q_sec_next = q_sec_reg; q_thr_next = q_thr_reg;
        a_sec_next = a_sec_reg; a_thr_next = a_thr_reg; a_bot_next = a_bot_reg;
        cmd_next = cmd_reg; p_next = p_reg; runnable_next = runnable_reg;
        queued_next = queued_reg; touched_next = touched_reg;
        len_next = len_reg;
        lv_next = lv_reg; cur_next = cur_reg; push_lv_next = push_lv_reg;
        i_next = i_reg; k_next = k_reg; pos_next = pos_reg; prun_next = prun_reg;
        push_en_next = push_en_reg; promo_next = promo_reg;
        rej_next = rej_reg; dem_next = dem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        nv_next = nv_reg; np_next = np_reg; nl_next = nl_reg;
        orej_next = orej_reg; odem_next = odem_reg; opc_next = opc_reg;
        qm_we = 1'b0; qm_wa = '0; qm_wd = p_reg;
        qm_ra = {lv_reg, i_reg[SW-1:0]};
        pm_we = 1'b0; pm_wa = p_idx; pm_wd = REC_RST;
        pm_ra = p_idx;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUANTUM_TOP:    q_top_next = cfg_data[5:0];
                CFG_QUANTUM_SECOND: q_sec_next = cfg_data[5:0];
                CFG_QUANTUM_THIRD:  q_thr_next = cfg_data[5:0];
                CFG_AGING_SECOND:   a_sec_next = cfg_data;
                CFG_AGING_THIRD:    a_thr_next = cfg_data;
                CFG_AGING_BOTTOM:   a_bot_next = cfg_data;
                default:            ;
            endcase
        end

        unique case (ctrl.op)
            ST_IDLE:
            begin
                if (ctrl.accept)
                begin
                    cmd_next = command; p_next = process; runnable_next = still_runnable;
                    rej_next = 1'b0; dem_next = 1'b0; promo_next = '0;
                end
            end
            ST_DECODE:
            begin
                if ((cmd_reg == CMD_ADMIT) || (cmd_reg == CMD_WAKE))
                begin
                    if (!in_range || queued_reg[p_idx])
                        rej_next = 1'b1;
                    else if (cmd_reg == CMD_ADMIT)
                    begin
                        pm_we = 1'b1;
                        touched_next[p_idx] = 1'b1;
                        queued_next[p_idx]  = 1'b1;
                        qm_we = 1'b1;
                        qm_wa = {TOP_LEVEL, len_reg[3][SW-1:0]};
                        len_next[3] = len_reg[3] + LW'(1);
                    end
                end
            end
            ST_WAKE:
            begin
                queued_next[p_idx] = 1'b1;
                qm_we = 1'b1;
                qm_wa = {pd[16:15], len_reg[pd[16:15]][SW-1:0]};
                len_next[pd[16:15]] = len_reg[pd[16:15]] + LW'(1);
            end
            ST_SLICE0:
            begin
                cur_next  = pd[16:15];
                prun_next = pd[14:9];
                pm_we = 1'b1;
                pm_wd = {pd[16:9], 9'd0};
                touched_next[p_idx] = 1'b1;
                lv_next = TOP_LEVEL; i_next = '0; k_next = '0;
            end
            ST_AGE_RD:
            begin
                if (i_reg == len_reg[lv_reg])
                begin
                    len_next[lv_reg] = k_reg;
                    if (lv_reg != 2'd0)
                    begin
                        lv_next = lv_reg - 2'd1; i_next = '0; k_next = '0;
                    end
                end
            end
            ST_AGE_Q:
            begin
                pm_ra = q_idx;
                if (qm_rdata_reg == p_reg)
                begin
                    qm_we = 1'b1;
                    qm_wa = {lv_reg, k_reg[SW-1:0]};
                    pos_next = k_reg;
                    k_next = k_reg + LW'(1);
                    i_next = i1;
                end
            end
            ST_AGE_P:
            begin
                // The queue entry read last cycle is still in the read register.
                pm_we = 1'b1;
                pm_wa = q_idx;
                qm_we = 1'b1;
                qm_wd = qm_rdata_reg;
                touched_next[q_idx] = 1'b1;
                i_next = i1;
                if ((lv_reg != TOP_LEVEL) && (w >= limit))
                begin
                    pm_wd = {lvl_up, 6'd0, 9'd0};
                    qm_wa = {lvl_up, len_reg[lvl_up][SW-1:0]};
                    len_next[lvl_up] = len_reg[lvl_up] + LW'(1);
                    promo_next = promo_reg + 7'd1;
                end
                else
                begin
                    pm_wd = {lv_reg, pd[14:9], w};
                    qm_wa = {lv_reg, k_reg[SW-1:0]};
                    k_next = k_reg + LW'(1);
                end
            end
            ST_RUN:
            begin
                pm_we = 1'b1;
                i_next = pos_reg;
                if (demote)
                begin
                    pm_wd = {cur_dn, 6'd0, 9'd0};
                    dem_next = 1'b1;
                    push_en_next = runnable_reg;
                    push_lv_next = cur_dn;
                    if (!runnable_reg)
                        queued_next[p_idx] = 1'b0;
                end
                else
                begin
                    pm_wd = {cur_reg, r, 9'd0};
                    push_lv_next = cur_reg;
                    push_en_next = runnable_reg && (cur_reg != 2'd0);
                    if (!runnable_reg)
                        queued_next[p_idx] = 1'b0;
                end
            end
            ST_SHIFT_RD:
            begin
                qm_ra = {cur_reg, i1[SW-1:0]};
                if (i1 >= len_reg[cur_reg])
                    len_next[cur_reg] = len_reg[cur_reg] - LW'(1);
            end
            ST_SHIFT_WR:
            begin
                qm_we = 1'b1;
                qm_wa = {cur_reg, i_reg[SW-1:0]};
                qm_wd = qm_rdata_reg;
                i_next = i1;
            end
            ST_PUSH:
            begin
                qm_we = 1'b1;
                qm_wa = {push_lv_reg, len_reg[push_lv_reg][SW-1:0]};
                len_next[push_lv_reg] = len_reg[push_lv_reg] + LW'(1);
            end
            ST_HEAD:
            begin
                qm_ra = {top, {SW{1'b0}}};
            end
            ST_RESULT:
            begin
                // Keep reading the head so the data survives a stalled output.
                qm_ra = {top, {SW{1'b0}}};
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    nv_next   = any;
                    np_next   = any ? qm_rdata_reg : 6'd0;
                    nl_next   = top;
                    orej_next = rej_reg;
                    odem_next = dem_reg;
                    opc_next  = promo_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (qm_we)
            queue_mem[qm_wa] <= qm_wd;
        if (pm_we)
            proc_mem[pm_wa] <= pm_wd;
        qm_rdata_reg <= queue_mem[qm_ra];
        pm_rdata_reg <= proc_mem[pm_ra];
        pm_touch_reg <= touched_next[pm_ra] & touched_reg[pm_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_top_reg <= QUANTUM_TOP_RST; q_sec_reg <= QUANTUM_SECOND_RST;
            q_thr_reg <= QUANTUM_THIRD_RST;
            a_sec_reg <= AGING_SECOND_RST; a_thr_reg <= AGING_THIRD_RST;
            a_bot_reg <= AGING_BOTTOM_RST;
            queued_reg  <= '0;
            touched_reg <= '0;
            for (int n = 0; n < LEVEL_COUNT; n++)
                len_reg[n] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_top_reg <= q_top_next; q_sec_reg <= q_sec_next; q_thr_reg <= q_thr_next;
            a_sec_reg <= a_sec_next; a_thr_reg <= a_thr_next; a_bot_reg <= a_bot_next;
            queued_reg  <= queued_next;
            touched_reg <= touched_next;
            len_reg     <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next; p_reg <= p_next; runnable_reg <= runnable_next;
        lv_reg <= lv_next; cur_reg <= cur_next; push_lv_reg <= push_lv_next;
        i_reg <= i_next; k_reg <= k_next; pos_reg <= pos_next; prun_reg <= prun_next;
        push_en_reg <= push_en_next; promo_reg <= promo_next;
        rej_reg <= rej_next; dem_reg <= dem_next;
        nv_reg <= nv_next; np_reg <= np_next; nl_reg <= nl_next;
        orej_reg <= orej_next; odem_reg <= odem_next; opc_reg <= opc_next;
    end

    assign out_valid      = out_valid_reg;
    assign next_valid     = nv_reg;
    assign next_process   = np_reg;
    assign next_level     = nl_reg;
    assign rejected       = orej_reg;
    assign demoted        = odem_reg;
    assign promoted_count = opc_reg;

endmodule

>>> hw/rtl/multilevel_feedback_queue_scheduler.sv
// Four-level feedback scheduler: one item in, one result out, one item at a time.
// Admit and ignored events pass decode, head read and result; a wake adds a queue
// write. Slice done walks every queued process through the aging step (queue read,
// self check, record update, the last skipped for the reporter), then, unless the
// reporter stays runnable on the bottom level, closes the gap it left by moving each
// entry behind it forward with a read and a write. After each result the block
// returns to idle and takes the next item there, also while the last result still
// waits in the output register. The user must write configuration through cfg_we,
// cfg_index and cfg_data while the block is idle; the block does not enforce it.
module multilevel_feedback_queue_scheduler
    import mfq_pkg::*;
#(
    parameter int PROCESS_COUNT = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [5:0] process,
    input  logic       still_runnable,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       next_valid,
    output logic [5:0] next_process,
    output logic [1:0] next_level,
    output logic       rejected,
    output logic       demoted,
    output logic [6:0] promoted_count
);

    ctrl_t   ctrl;
    status_t status;

    mfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    mfq_datapath #(
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .process        (process),
        .still_runnable (still_runnable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_valid     (next_valid),
        .next_process   (next_process),
        .next_level     (next_level),
        .rejected       (rejected),
        .demoted        (demoted),
        .promoted_count (promoted_count),
        .ctrl           (ctrl),
        .status         (status)
    );

endmodule

>>> hw/rtl/mfq_checker.sv
module mfq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       next_valid,
    input logic [5:0] next_process,
    input logic [1:0] next_level,
    input logic       rejected,
    input logic       demoted,
    input logic [6:0] promoted_count
);

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_process)
            && $stable(next_level) && $stable(promoted_count))
        else $error("stalled result changed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !next_valid |-> next_process == 6'd0 && next_level == 2'd0)
        else $error("empty result names a process");

    // A refused event changes nothing, so it cannot demote or age anyone.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !demoted && promoted_count == 7'd0)
        else $error("rejected item reports changes");

endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_valid     (next_valid),
    .next_process   (next_process),
    .next_level     (next_level),
    .rejected       (rejected),
    .demoted        (demoted),
    .promoted_count (promoted_count)
);
